// ----- hw/rtl/dbvp_pkg.sv -----
// dbvp_pkg: shared types, codes and constants for the distance based velocity profile
// used by every module under hw/rtl; no dependencies
package dbvp_pkg;

    localparam int POS_W   = 32;
    localparam int DIST_W  = 32;
    localparam int VEL_W   = 20;
    localparam int SHARE_W = 17;
    localparam int PHASE_W = 2;
    localparam int PROD_W  = 64;
    localparam int DIVR_W  = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int OP_W    = 5;
    localparam int PAIR_W  = 2;

    localparam logic [DIST_W-1:0] NEAR_GOAL = 32'd3277;

    localparam logic [VEL_W-1:0]   RST_MAX_VELOCITY  = 20'd65536;
    localparam logic [SHARE_W-1:0] RST_ACCEL_SHARE   = 17'd13107;
    localparam logic [SHARE_W-1:0] RST_DECEL_SHARE   = 17'd13107;
    localparam logic [SHARE_W-1:0] RST_INERTIA_GAIN  = 17'd52429;
    localparam logic [VEL_W-1:0]   RST_ACCEL_RATE    = 20'd13107;
    localparam logic [VEL_W-1:0]   RST_MIN_DECEL_VEL = 20'd0;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SHARE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_SHARE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DECEL_VEL = 3'd5;

    localparam logic [PHASE_W-1:0] PH_ACCEL  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_CRUISE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DECEL  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE   = 2'd3;

    localparam logic [PAIR_W-1:0] PAIR_PATH = 2'd0;
    localparam logic [PAIR_W-1:0] PAIR_GOAL = 2'd1;
    localparam logic [PAIR_W-1:0] PAIR_MOVE = 2'd2;

    localparam logic [OP_W-1:0] OP_NONE        = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD        = 5'd1;
    localparam logic [OP_W-1:0] OP_START_MOVE  = 5'd2;
    localparam logic [OP_W-1:0] OP_SQ_X        = 5'd3;
    localparam logic [OP_W-1:0] OP_SQ_Y        = 5'd4;
    localparam logic [OP_W-1:0] OP_SQ_SUM      = 5'd5;
    localparam logic [OP_W-1:0] OP_SQRT_GO     = 5'd6;
    localparam logic [OP_W-1:0] OP_SPAN_STORE  = 5'd7;
    localparam logic [OP_W-1:0] OP_MUL_DECEL   = 5'd8;
    localparam logic [OP_W-1:0] OP_DIV_GO_SPAN = 5'd9;
    localparam logic [OP_W-1:0] OP_ASPAN_STORE = 5'd10;
    localparam logic [OP_W-1:0] OP_MUL_VMAX    = 5'd11;
    localparam logic [OP_W-1:0] OP_DIV_GO_RAMP = 5'd12;
    localparam logic [OP_W-1:0] OP_RAMP_STORE  = 5'd13;
    localparam logic [OP_W-1:0] OP_MUL_ASPAN   = 5'd14;
    localparam logic [OP_W-1:0] OP_PEAK_STORE  = 5'd15;
    localparam logic [OP_W-1:0] OP_MUL_TRAV    = 5'd16;
    localparam logic [OP_W-1:0] OP_VEL_ACCEL   = 5'd17;
    localparam logic [OP_W-1:0] OP_VEL_CRUISE  = 5'd18;
    localparam logic [OP_W-1:0] OP_MUL_PEAK    = 5'd19;
    localparam logic [OP_W-1:0] OP_MUL_DROP    = 5'd20;
    localparam logic [OP_W-1:0] OP_DROP_SUB    = 5'd21;
    localparam logic [OP_W-1:0] OP_VEL_DECEL   = 5'd22;
    localparam logic [OP_W-1:0] OP_MUL_CUT     = 5'd23;
    localparam logic [OP_W-1:0] OP_VEL_BLEND   = 5'd24;
    localparam logic [OP_W-1:0] OP_FINISH      = 5'd25;

    typedef struct packed {
        logic signed [POS_W-1:0] goal_x;
        logic signed [POS_W-1:0] goal_y;
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [POS_W-1:0] robot_x;
        logic signed [POS_W-1:0] robot_y;
        logic [VEL_W-1:0]        current_velocity;
    } in_item_t;

    typedef struct packed {
        logic [VEL_W-1:0]   command_velocity;
        logic [PHASE_W-1:0] phase;
        logic               goal_done;
    } out_item_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PAIR_W-1:0] pair;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic sqrt_done;
        logic div_done;
        logic ramp_gt;
        logic in_accel;
        logic in_cruise;
        logic vel_lt_cur;
        logic out_full;
    } dp_stat_t;

endpackage

// ----- hw/rtl/distance_based_velocity_profile.sv -----
// distance_based_velocity_profile: top level, joins sequencer and datapath
// depends on dbvp_pkg, dbvp_ctrl, dbvp_dp (which holds dbvp_sqrt and dbvp_div)
//
// Usage:
//   in_item/in_valid/in_stall carries one odometry request; it is taken when
//   in_valid is high and in_stall low. Each request gives exactly one result on
//   out_item/out_valid/out_stall, taken when out_valid is high and out_stall low.
//   cfg_valid/cfg_ready/cfg_index/cfg_data writes a register; cfg_ready is
//   always high. Write only while no request is in flight.
// Timing:
//   one request at a time. A request in acceleration needs one more square root
//   than one in cruise, and one in deceleration needs one more root and, with the
//   inertia blend, a multiply and a blend step; the first request of a move adds
//   the path length root and two 64-step divisions, and one more root when the
//   peak speed needs its own root. The square root has 32 steps and the divider
//   64. The result sits in an output register, so a new request is taken while it
//   waits; a stalled receiver holds the next result back in the sequencer until
//   the register frees.
// Reset:
//   rst_n clears the move state, loads the register defaults and empties the
//   output register.
module distance_based_velocity_profile (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dbvp_pkg::in_item_t                in_item,
    input  logic                              in_valid,
    output logic                              in_stall,
    output dbvp_pkg::out_item_t               out_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dbvp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dbvp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    dbvp_pkg::dp_cmd_t  cmd;
    dbvp_pkg::dp_stat_t stat;

    dbvp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    dbvp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign cfg_ready = 1'b1;

endmodule

// ----- hw/rtl/dbvp_sqrt.sv -----
// dbvp_sqrt: iterative floor square root, one result bit per cycle
// depends on dbvp_pkg
module dbvp_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [dbvp_pkg::PROD_W-1:0]    radicand,
    output logic [dbvp_pkg::DIST_W-1:0]    root,
    output logic                           busy,
    output logic                           done
);

    localparam int STEPS = dbvp_pkg::PROD_W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam int REM_W = dbvp_pkg::DIST_W + 1;

    logic [dbvp_pkg::PROD_W-1:0] rad_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [dbvp_pkg::DIST_W-1:0] root_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [REM_W+1:0]            rem_sh;
    logic [REM_W+1:0]            trial;
    logic [REM_W+1:0]            diff;
    logic                        ge;

    assign rem_sh = {rem_reg, rad_reg[dbvp_pkg::PROD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= CNT_W'(STEPS - 1);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[dbvp_pkg::PROD_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[dbvp_pkg::DIST_W-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign root = root_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- hw/rtl/dbvp_div.sv -----
// dbvp_div: restoring divider, one quotient bit per cycle
// depends on dbvp_pkg
module dbvp_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [dbvp_pkg::PROD_W-1:0]    dividend,
    input  logic [dbvp_pkg::DIVR_W-1:0]    divisor,
    output logic [dbvp_pkg::PROD_W-1:0]    quotient,
    output logic                           done
);

    localparam int STEPS = dbvp_pkg::PROD_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int DW    = dbvp_pkg::DIVR_W;

    logic [dbvp_pkg::PROD_W-1:0] dvd_reg;
    logic [DW-1:0]               rem_reg;
    logic [DW-1:0]               dsr_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [DW:0]                 rem_sh;
    logic [DW:0]                 diff;
    logic                        ge;

    assign rem_sh = {rem_reg, dvd_reg[dbvp_pkg::PROD_W-1]};
    assign ge     = rem_sh >= {1'b0, dsr_reg};
    assign diff   = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else if (start)
        begin
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
            cnt_reg  <= CNT_W'(STEPS - 1);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[dbvp_pkg::PROD_W-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

// ----- hw/rtl/dbvp_dp.sv -----
// dbvp_dp: datapath with config registers, move state, shared multiplier,
// square root and divider units and the output register; depends on dbvp_pkg
module dbvp_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dbvp_pkg::dp_cmd_t                 cmd,
    output dbvp_pkg::dp_stat_t                stat,
    input  dbvp_pkg::in_item_t                in_item,
    output dbvp_pkg::out_item_t               out_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              cfg_valid,
    input  logic [dbvp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dbvp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int VW = dbvp_pkg::VEL_W;
    localparam int SW = dbvp_pkg::SHARE_W;
    localparam int DW = dbvp_pkg::DIST_W;
    localparam int PW = dbvp_pkg::PROD_W;

    logic [VW-1:0] max_vel_reg;
    logic [SW-1:0] accel_share_reg;
    logic [SW-1:0] decel_share_reg;
    logic [SW-1:0] gain_reg;
    logic [VW-1:0] accel_rate_reg;
    logic [VW-1:0] min_vel_reg;

    dbvp_pkg::in_item_t item_reg;
    logic                active_reg;
    logic [DW-1:0]       last_x_reg;
    logic [DW-1:0]       last_y_reg;
    logic [DW-1:0]       trav_reg;
    logic [DW-1:0]       path_reg;
    logic [DW-1:0]       aspan_reg;
    logic [DW-1:0]       ramp_reg;
    logic [VW-1:0]       peak_reg;
    logic [DW-1:0]       to_goal_reg;
    logic [PW-1:0]       sqa_reg;
    logic [PW-1:0]       sqb_reg;
    logic [PW:0]         rad_reg;
    logic [VW-1:0]       vel_reg;
    logic [dbvp_pkg::PHASE_W-1:0] phase_reg;
    dbvp_pkg::out_item_t out_reg;
    logic                out_valid_reg;

    logic signed [DW-1:0] ax, ay, bx, by;
    logic [DW:0]          dx, dy;
    logic [DW-1:0]        ux, uy;
    logic [DW-1:0]        mul_a, mul_b;
    logic [PW-1:0]        prod;
    logic [DW-1:0]        rate2;
    logic [SW:0]          share_sum;
    logic [DW-1:0]        root;
    logic                 sqrt_busy;
    logic                 sqrt_done;
    logic [PW-1:0]        quot;
    logic                 div_done;
    logic [DW-1:0]        span_val;
    logic [DW:0]          trav_sum;
    logic [VW-1:0]        root_cap;
    logic [VW-1:0]        decel_v;
    logic [VW:0]          cut;
    logic                 finish_goal;

    always_comb
    begin
        unique case (cmd.pair)
            dbvp_pkg::PAIR_PATH:
            begin
                ax = item_reg.goal_x;  ay = item_reg.goal_y;
                bx = item_reg.start_x; by = item_reg.start_y;
            end
            dbvp_pkg::PAIR_GOAL:
            begin
                ax = item_reg.goal_x;  ay = item_reg.goal_y;
                bx = item_reg.robot_x; by = item_reg.robot_y;
            end
            default:
            begin
                ax = item_reg.robot_x; ay = item_reg.robot_y;
                bx = last_x_reg;       by = last_y_reg;
            end
        endcase
    end

    assign dx = {ax[DW-1], ax} - {bx[DW-1], bx};
    assign dy = {ay[DW-1], ay} - {by[DW-1], by};
    assign ux = dx[DW] ? DW'(-dx) : dx[DW-1:0];
    assign uy = dy[DW] ? DW'(-dy) : dy[DW-1:0];

    assign rate2     = {{(DW-VW-1){1'b0}}, accel_rate_reg, 1'b0};
    assign share_sum = {1'b0, accel_share_reg} + {1'b0, decel_share_reg};

    // one shared multiplier, operands picked by the command
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            dbvp_pkg::OP_SQ_X:      begin mul_a = ux; mul_b = ux; end
            dbvp_pkg::OP_SQ_Y:      begin mul_a = uy; mul_b = uy; end
            dbvp_pkg::OP_MUL_DECEL:
            begin
                mul_a = path_reg;
                mul_b = DW'(decel_share_reg);
            end
            dbvp_pkg::OP_MUL_VMAX:
            begin
                mul_a = DW'(max_vel_reg);
                mul_b = DW'(max_vel_reg);
            end
            dbvp_pkg::OP_MUL_ASPAN: begin mul_a = rate2; mul_b = aspan_reg; end
            dbvp_pkg::OP_MUL_TRAV:  begin mul_a = rate2; mul_b = trav_reg; end
            dbvp_pkg::OP_MUL_PEAK:
            begin
                mul_a = DW'(peak_reg);
                mul_b = DW'(peak_reg);
            end
            dbvp_pkg::OP_MUL_DROP:
            begin
                mul_a = rate2;
                mul_b = trav_reg - aspan_reg;
            end
            dbvp_pkg::OP_MUL_CUT:
            begin
                mul_a = DW'(gain_reg);
                mul_b = DW'(item_reg.current_velocity - vel_reg);
            end
            default: ;
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    dbvp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == dbvp_pkg::OP_SQRT_GO),
        .radicand (rad_reg[PW-1:0]),
        .root     (root),
        .busy     (sqrt_busy),
        .done     (sqrt_done)
    );

    dbvp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    ((cmd.op == dbvp_pkg::OP_DIV_GO_SPAN) ||
                   (cmd.op == dbvp_pkg::OP_DIV_GO_RAMP)),
        .dividend (sqa_reg),
        .divisor  ((cmd.op == dbvp_pkg::OP_DIV_GO_SPAN) ?
                   dbvp_pkg::DIVR_W'(share_sum) : dbvp_pkg::DIVR_W'(rate2)),
        .quotient (quot),
        .done     (div_done)
    );

    assign span_val    = rad_reg[PW] ? '1 : root;
    assign trav_sum    = {1'b0, trav_reg} + {1'b0, span_val};
    assign root_cap    = (root > DW'(max_vel_reg)) ? max_vel_reg : root[VW-1:0];
    assign decel_v     = (root[VW-1:0] < min_vel_reg) ? min_vel_reg : root[VW-1:0];
    assign cut         = sqa_reg[VW+16:16];
    assign finish_goal = ({1'b0, trav_reg} + {1'b0, dbvp_pkg::NEAR_GOAL}) >= {1'b0, path_reg};

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_vel_reg     <= dbvp_pkg::RST_MAX_VELOCITY;
            accel_share_reg <= dbvp_pkg::RST_ACCEL_SHARE;
            decel_share_reg <= dbvp_pkg::RST_DECEL_SHARE;
            gain_reg        <= dbvp_pkg::RST_INERTIA_GAIN;
            accel_rate_reg  <= dbvp_pkg::RST_ACCEL_RATE;
            min_vel_reg     <= dbvp_pkg::RST_MIN_DECEL_VEL;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dbvp_pkg::REG_MAX_VELOCITY:  max_vel_reg     <= cfg_data[VW-1:0];
                dbvp_pkg::REG_ACCEL_SHARE:   accel_share_reg <= cfg_data[SW-1:0];
                dbvp_pkg::REG_DECEL_SHARE:   decel_share_reg <= cfg_data[SW-1:0];
                dbvp_pkg::REG_INERTIA_GAIN:  gain_reg        <= cfg_data[SW-1:0];
                dbvp_pkg::REG_ACCEL_RATE:    accel_rate_reg  <= cfg_data[VW-1:0];
                dbvp_pkg::REG_MIN_DECEL_VEL: min_vel_reg     <= cfg_data[VW-1:0];
                default: ;
            endcase
        end
    end

    // move state and work registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            trav_reg      <= '0;
            path_reg      <= '0;
            aspan_reg     <= '0;
            ramp_reg      <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            item_reg      <= '0;
            to_goal_reg   <= '0;
            sqa_reg       <= '0;
            sqb_reg       <= '0;
            rad_reg       <= '0;
            vel_reg       <= '0;
            phase_reg     <= dbvp_pkg::PH_ACCEL;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                dbvp_pkg::OP_LOAD:       item_reg <= in_item;
                dbvp_pkg::OP_START_MOVE:
                begin
                    last_x_reg <= item_reg.robot_x;
                    last_y_reg <= item_reg.robot_y;
                    trav_reg   <= '0;
                    active_reg <= 1'b1;
                end
                dbvp_pkg::OP_SQ_X:       sqa_reg <= prod;
                dbvp_pkg::OP_SQ_Y:       sqb_reg <= prod;
                dbvp_pkg::OP_SQ_SUM:     rad_reg <= {1'b0, sqa_reg} + {1'b0, sqb_reg};
                dbvp_pkg::OP_SPAN_STORE:
                begin
                    unique case (cmd.pair)
                        dbvp_pkg::PAIR_PATH: path_reg    <= span_val;
                        dbvp_pkg::PAIR_GOAL: to_goal_reg <= span_val;
                        default:
                        begin
                            trav_reg   <= trav_sum[DW] ? '1 : trav_sum[DW-1:0];
                            last_x_reg <= item_reg.robot_x;
                            last_y_reg <= item_reg.robot_y;
                        end
                    endcase
                end
                dbvp_pkg::OP_MUL_DECEL:  sqa_reg <= prod;
                dbvp_pkg::OP_ASPAN_STORE:
                    aspan_reg <= (share_sum == '0) ? {1'b0, path_reg[DW-1:1]} : quot[DW-1:0];
                dbvp_pkg::OP_MUL_VMAX:   sqa_reg <= prod;
                dbvp_pkg::OP_RAMP_STORE:
                begin
                    if (accel_rate_reg == '0 || quot[PW-1:DW] != '0)
                    begin
                        ramp_reg <= '1;
                    end
                    else
                    begin
                        ramp_reg <= quot[DW-1:0];
                    end
                    peak_reg <= max_vel_reg;
                end
                dbvp_pkg::OP_MUL_ASPAN:  rad_reg <= {1'b0, prod};
                dbvp_pkg::OP_PEAK_STORE:
                begin
                    ramp_reg <= aspan_reg;
                    peak_reg <= root_cap;
                end
                dbvp_pkg::OP_MUL_TRAV:   rad_reg <= {1'b0, prod};
                dbvp_pkg::OP_VEL_ACCEL:
                begin
                    vel_reg   <= root_cap;
                    phase_reg <= dbvp_pkg::PH_ACCEL;
                end
                dbvp_pkg::OP_VEL_CRUISE:
                begin
                    vel_reg   <= peak_reg;
                    phase_reg <= dbvp_pkg::PH_CRUISE;
                end
                dbvp_pkg::OP_MUL_PEAK:   sqa_reg <= prod;
                dbvp_pkg::OP_MUL_DROP:   sqb_reg <= prod;
                dbvp_pkg::OP_DROP_SUB:
                    rad_reg <= (sqa_reg > sqb_reg) ? {1'b0, sqa_reg - sqb_reg} : '0;
                dbvp_pkg::OP_VEL_DECEL:
                begin
                    vel_reg   <= decel_v;
                    phase_reg <= dbvp_pkg::PH_DECEL;
                end
                dbvp_pkg::OP_MUL_CUT:    sqa_reg <= prod;
                dbvp_pkg::OP_VEL_BLEND:
                    vel_reg <= (cut > {1'b0, item_reg.current_velocity}) ? '0 :
                               item_reg.current_velocity - cut[VW-1:0];
                dbvp_pkg::OP_FINISH:
                begin
                    out_valid_reg <= 1'b1;
                    if (finish_goal)
                    begin
                        active_reg               <= 1'b0;
                        out_reg.command_velocity <= '0;
                        out_reg.phase            <= dbvp_pkg::PH_DONE;
                        out_reg.goal_done        <= 1'b1;
                    end
                    else
                    begin
                        // near the goal while slowing down
                        out_reg.command_velocity <=
                            (phase_reg == dbvp_pkg::PH_DECEL &&
                             to_goal_reg < dbvp_pkg::NEAR_GOAL) ? '0 : vel_reg;
                        out_reg.phase            <= phase_reg;
                        out_reg.goal_done        <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign stat.active     = active_reg;
    assign stat.sqrt_done  = sqrt_done;
    assign stat.div_done   = div_done;
    assign stat.ramp_gt    = ramp_reg > aspan_reg;
    assign stat.in_accel   = trav_reg < ramp_reg;
    assign stat.in_cruise  = trav_reg < aspan_reg;
    assign stat.vel_lt_cur = vel_reg < item_reg.current_velocity;
    assign stat.out_full   = out_valid_reg;

    assign out_item  = out_reg;
    assign out_valid = out_valid_reg;

    a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == dbvp_pkg::OP_SQRT_GO) |-> !sqrt_busy)
        else $error("square root started while busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == dbvp_pkg::OP_FINISH) |-> !out_valid_reg)
        else $error("result register overwritten");

    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.goal_done == (out_reg.phase == dbvp_pkg::PH_DONE)))
        else $error("goal_done and phase disagree");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == dbvp_pkg::OP_FINISH && finish_goal) |=> !active_reg)
        else $error("move not re-armed at goal");

endmodule

// ----- hw/rtl/dbvp_ctrl.sv -----
// dbvp_ctrl: sequencer that steps the datapath through one request
// depends on dbvp_pkg
module dbvp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  dbvp_pkg::dp_stat_t stat,
    output dbvp_pkg::dp_cmd_t  cmd
);

    localparam logic [5:0] ST_IDLE   = 6'd0;
    localparam logic [5:0] ST_NEW    = 6'd1;
    localparam logic [5:0] ST_SQX    = 6'd2;
    localparam logic [5:0] ST_SQY    = 6'd3;
    localparam logic [5:0] ST_SUM    = 6'd4;
    localparam logic [5:0] ST_SGO    = 6'd5;
    localparam logic [5:0] ST_SWAIT  = 6'd6;
    localparam logic [5:0] ST_SSTORE = 6'd7;
    localparam logic [5:0] ST_PMUL   = 6'd8;
    localparam logic [5:0] ST_PDGO   = 6'd9;
    localparam logic [5:0] ST_PDW    = 6'd10;
    localparam logic [5:0] ST_PAST   = 6'd11;
    localparam logic [5:0] ST_RMUL   = 6'd12;
    localparam logic [5:0] ST_RDGO   = 6'd13;
    localparam logic [5:0] ST_RDW    = 6'd14;
    localparam logic [5:0] ST_RST    = 6'd15;
    localparam logic [5:0] ST_RCHK   = 6'd16;
    localparam logic [5:0] ST_KMUL   = 6'd17;
    localparam logic [5:0] ST_KGO    = 6'd18;
    localparam logic [5:0] ST_KW     = 6'd19;
    localparam logic [5:0] ST_KST    = 6'd20;
    localparam logic [5:0] ST_PSEL   = 6'd21;
    localparam logic [5:0] ST_AMUL   = 6'd22;
    localparam logic [5:0] ST_AGO    = 6'd23;
    localparam logic [5:0] ST_AW     = 6'd24;
    localparam logic [5:0] ST_AST    = 6'd25;
    localparam logic [5:0] ST_CRU    = 6'd26;
    localparam logic [5:0] ST_DPK    = 6'd27;
    localparam logic [5:0] ST_DDR    = 6'd28;
    localparam logic [5:0] ST_DSUB   = 6'd29;
    localparam logic [5:0] ST_DGO    = 6'd30;
    localparam logic [5:0] ST_DW     = 6'd31;
    localparam logic [5:0] ST_DST    = 6'd32;
    localparam logic [5:0] ST_DCHK   = 6'd33;
    localparam logic [5:0] ST_DCUT   = 6'd34;
    localparam logic [5:0] ST_DBL    = 6'd35;
    localparam logic [5:0] ST_FIN    = 6'd36;

    logic [5:0]                      state_reg, state_next;
    logic [dbvp_pkg::PAIR_W-1:0]     pair_reg, pair_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pair_reg  <= dbvp_pkg::PAIR_PATH;
        end
        else
        begin
            state_reg <= state_next;
            pair_reg  <= pair_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pair_next  = pair_reg;
        cmd.op     = dbvp_pkg::OP_NONE;
        cmd.pair   = pair_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = dbvp_pkg::OP_LOAD;
                    if (stat.active)
                    begin
                        pair_next  = dbvp_pkg::PAIR_GOAL;
                        state_next = ST_SQX;
                    end
                    else
                    begin
                        state_next = ST_NEW;
                    end
                end
            end
            ST_NEW:
            begin
                cmd.op     = dbvp_pkg::OP_START_MOVE;
                pair_next  = dbvp_pkg::PAIR_PATH;
                state_next = ST_SQX;
            end
            ST_SQX:   begin cmd.op = dbvp_pkg::OP_SQ_X;   state_next = ST_SQY; end
            ST_SQY:   begin cmd.op = dbvp_pkg::OP_SQ_Y;   state_next = ST_SUM; end
            ST_SUM:   begin cmd.op = dbvp_pkg::OP_SQ_SUM; state_next = ST_SGO; end
            ST_SGO:   begin cmd.op = dbvp_pkg::OP_SQRT_GO; state_next = ST_SWAIT; end
            ST_SWAIT: if (stat.sqrt_done) state_next = ST_SSTORE;
            ST_SSTORE:
            begin
                cmd.op = dbvp_pkg::OP_SPAN_STORE;
                unique case (pair_reg)
                    dbvp_pkg::PAIR_PATH: state_next = ST_PMUL;
                    dbvp_pkg::PAIR_GOAL:
                    begin
                        pair_next  = dbvp_pkg::PAIR_MOVE;
                        state_next = ST_SQX;
                    end
                    default: state_next = ST_PSEL;
                endcase
            end
            ST_PMUL:  begin cmd.op = dbvp_pkg::OP_MUL_DECEL;   state_next = ST_PDGO; end
            ST_PDGO:  begin cmd.op = dbvp_pkg::OP_DIV_GO_SPAN; state_next = ST_PDW; end
            ST_PDW:   if (stat.div_done) state_next = ST_PAST;
            ST_PAST:  begin cmd.op = dbvp_pkg::OP_ASPAN_STORE; state_next = ST_RMUL; end
            ST_RMUL:  begin cmd.op = dbvp_pkg::OP_MUL_VMAX;    state_next = ST_RDGO; end
            ST_RDGO:  begin cmd.op = dbvp_pkg::OP_DIV_GO_RAMP; state_next = ST_RDW; end
            ST_RDW:   if (stat.div_done) state_next = ST_RST;
            ST_RST:   begin cmd.op = dbvp_pkg::OP_RAMP_STORE;  state_next = ST_RCHK; end
            ST_RCHK:
            begin
                if (stat.ramp_gt)
                begin
                    state_next = ST_KMUL;
                end
                else
                begin
                    pair_next  = dbvp_pkg::PAIR_GOAL;
                    state_next = ST_SQX;
                end
            end
            ST_KMUL:  begin cmd.op = dbvp_pkg::OP_MUL_ASPAN; state_next = ST_KGO; end
            ST_KGO:   begin cmd.op = dbvp_pkg::OP_SQRT_GO;   state_next = ST_KW; end
            ST_KW:    if (stat.sqrt_done) state_next = ST_KST;
            ST_KST:
            begin
                cmd.op     = dbvp_pkg::OP_PEAK_STORE;
                pair_next  = dbvp_pkg::PAIR_GOAL;
                state_next = ST_SQX;
            end
            ST_PSEL:
            begin
                if (stat.in_accel)
                begin
                    state_next = ST_AMUL;
                end
                else if (stat.in_cruise)
                begin
                    state_next = ST_CRU;
                end
                else
                begin
                    state_next = ST_DPK;
                end
            end
            ST_AMUL:  begin cmd.op = dbvp_pkg::OP_MUL_TRAV;   state_next = ST_AGO; end
            ST_AGO:   begin cmd.op = dbvp_pkg::OP_SQRT_GO;    state_next = ST_AW; end
            ST_AW:    if (stat.sqrt_done) state_next = ST_AST;
            ST_AST:   begin cmd.op = dbvp_pkg::OP_VEL_ACCEL;  state_next = ST_FIN; end
            ST_CRU:   begin cmd.op = dbvp_pkg::OP_VEL_CRUISE; state_next = ST_FIN; end
            ST_DPK:   begin cmd.op = dbvp_pkg::OP_MUL_PEAK;   state_next = ST_DDR; end
            ST_DDR:   begin cmd.op = dbvp_pkg::OP_MUL_DROP;   state_next = ST_DSUB; end
            ST_DSUB:  begin cmd.op = dbvp_pkg::OP_DROP_SUB;   state_next = ST_DGO; end
            ST_DGO:   begin cmd.op = dbvp_pkg::OP_SQRT_GO;    state_next = ST_DW; end
            ST_DW:    if (stat.sqrt_done) state_next = ST_DST;
            ST_DST:   begin cmd.op = dbvp_pkg::OP_VEL_DECEL;  state_next = ST_DCHK; end
            ST_DCHK:  state_next = stat.vel_lt_cur ? ST_DCUT : ST_FIN;
            ST_DCUT:  begin cmd.op = dbvp_pkg::OP_MUL_CUT;    state_next = ST_DBL; end
            ST_DBL:   begin cmd.op = dbvp_pkg::OP_VEL_BLEND;  state_next = ST_FIN; end
            ST_FIN:
            begin
                if (!stat.out_full)
                begin
                    cmd.op     = dbvp_pkg::OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// ----- dv/distance_based_velocity_profile_test.sv -----
// distance_based_velocity_profile_test: self-checking testbench for the velocity profile block
// depends on dbvp_pkg and distance_based_velocity_profile; the predictor lives in this file
`timescale 1ns / 100ps

module distance_based_velocity_profile_test;

    localparam int METER = 65536;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int RANDOM_ITEMS = 1250;

    typedef struct {
        dbvp_pkg::in_item_t  item;
        bit                  typed;
        dbvp_pkg::out_item_t want;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    dbvp_pkg::in_item_t  in_item = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    dbvp_pkg::out_item_t out_item;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [dbvp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dbvp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    distance_based_velocity_profile i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor copy of registers and move state
    longint unsigned vmax, ashare, dshare, igain, arate, vmin;
    bit              moving;
    logic signed [dbvp_pkg::POS_W-1:0] prev_x, prev_y;
    longint unsigned trav, path_total, aspan, rspan, peak;

    dbvp_pkg::out_item_t command_queue[$];
    int  errors = 0;
    int  sent = 0;
    bit  calm = 1'b0;
    bit  hold_request = 1'b0;
    int  idle_cycles = 0;

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned gap_length(logic signed [dbvp_pkg::POS_W-1:0] ax,
            logic signed [dbvp_pkg::POS_W-1:0] ay, logic signed [dbvp_pkg::POS_W-1:0] bx,
            logic signed [dbvp_pkg::POS_W-1:0] by);
        longint dx, dy;
        longint unsigned ux, uy, sx, sy, r;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        sx = ux * ux;
        sy = uy * uy;
        if (sx > ~sy)
            return 64'hFFFF_FFFF;
        r = root_floor(sx + sy);
        return r > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : r;
    endfunction

    function automatic void plan_move();
        longint unsigned share_sum, ramp, p;
        share_sum = ashare + dshare;
        if (share_sum == 0)
            aspan = path_total >> 1;
        else
            aspan = (path_total * dshare) / share_sum;
        if (arate == 0)
            ramp = 64'hFFFF_FFFF;
        else
        begin
            ramp = (vmax * vmax) / (2 * arate);
            if (ramp > 64'hFFFF_FFFF)
                ramp = 64'hFFFF_FFFF;
        end
        if (ramp > aspan)
        begin
            p = root_floor(2 * arate * aspan);
            rspan = aspan;
            peak = p > vmax ? vmax : p;
        end
        else
        begin
            rspan = ramp;
            peak = vmax;
        end
    endfunction

    function automatic dbvp_pkg::out_item_t profile_step(dbvp_pkg::in_item_t it);
        longint unsigned vel, moved, cur, pk2, drop, cut, to_goal;
        dbvp_pkg::out_item_t r;
        cur = it.current_velocity;
        if (!moving)
        begin
            prev_x = it.robot_x;
            prev_y = it.robot_y;
            trav = 0;
            moving = 1'b1;
            path_total = gap_length(it.goal_x, it.goal_y, it.start_x, it.start_y);
            plan_move();
        end
        to_goal = gap_length(it.goal_x, it.goal_y, it.robot_x, it.robot_y);
        moved = trav + gap_length(it.robot_x, it.robot_y, prev_x, prev_y);
        trav = moved > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : moved;
        prev_x = it.robot_x;
        prev_y = it.robot_y;
        r.goal_done = 1'b0;
        if (trav < rspan)
        begin
            r.phase = dbvp_pkg::PH_ACCEL;
            vel = root_floor(2 * arate * trav);
            if (vel > vmax)
                vel = vmax;
        end
        else if (trav < aspan)
        begin
            r.phase = dbvp_pkg::PH_CRUISE;
            vel = peak;
        end
        else
        begin
            r.phase = dbvp_pkg::PH_DECEL;
            pk2 = peak * peak;
            drop = 2 * arate * (trav - aspan);
            vel = pk2 > drop ? root_floor(pk2 - drop) : 0;
            if (vel < vmin)
                vel = vmin;
            if (vel < cur)
            begin
                cut = (igain * (cur - vel)) >> 16;
                vel = cut > cur ? 0 : cur - cut;
            end
            if (to_goal < dbvp_pkg::NEAR_GOAL)
                vel = 0;
        end
        if (trav + dbvp_pkg::NEAR_GOAL >= path_total)
        begin
            moving = 1'b0;
            vel = 0;
            r.phase = dbvp_pkg::PH_DONE;
            r.goal_done = 1'b1;
        end
        r.command_velocity = vel[dbvp_pkg::VEL_W-1:0];
        return r;
    endfunction

    function automatic dbvp_pkg::in_item_t odometry(int gx, int gy, int sx, int sy, int rx,
            int ry, int cv);
        dbvp_pkg::in_item_t it;
        it.goal_x = gx;
        it.goal_y = gy;
        it.start_x = sx;
        it.start_y = sy;
        it.robot_x = rx;
        it.robot_y = ry;
        it.current_velocity = cv[dbvp_pkg::VEL_W-1:0];
        return it;
    endfunction

    task automatic send_request(dbvp_pkg::in_item_t it, bit typed, dbvp_pkg::out_item_t want);
        int gap;
        dbvp_pkg::out_item_t predicted;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        predicted = profile_step(it);
        command_queue.push_back(typed ? want : predicted);
        sent++;
    endtask

    task automatic write_reg(logic [dbvp_pkg::CFG_IDX_W-1:0] idx,
            logic [dbvp_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            dbvp_pkg::REG_MAX_VELOCITY:  vmax = value;
            dbvp_pkg::REG_ACCEL_SHARE:   ashare = value[dbvp_pkg::SHARE_W-1:0];
            dbvp_pkg::REG_DECEL_SHARE:   dshare = value[dbvp_pkg::SHARE_W-1:0];
            dbvp_pkg::REG_INERTIA_GAIN:  igain = value[dbvp_pkg::SHARE_W-1:0];
            dbvp_pkg::REG_ACCEL_RATE:    arate = value;
            dbvp_pkg::REG_MIN_DECEL_VEL: vmin = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (command_queue.size() == 0);
        repeat (150) @(posedge clk);
    endtask

    task automatic load_profile(int unsigned v, int unsigned a, int unsigned d,
            int unsigned g, int unsigned r, int unsigned m);
        drain();
        write_reg(dbvp_pkg::REG_MAX_VELOCITY, v);
        write_reg(dbvp_pkg::REG_ACCEL_SHARE, a);
        write_reg(dbvp_pkg::REG_DECEL_SHARE, d);
        write_reg(dbvp_pkg::REG_INERTIA_GAIN, g);
        write_reg(dbvp_pkg::REG_ACCEL_RATE, r);
        write_reg(dbvp_pkg::REG_MIN_DECEL_VEL, m);
    endtask

    // one move along a straight line with jitter, or a burst of raw noise
    task automatic random_move();
        int sx, sy, dx, dy, gx, gy, steps, k, kk, cv, jit;
        dbvp_pkg::out_item_t none;
        none = '0;
        calm = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 4))
                send_request(odometry($urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom), 1'b0, none);
            return;
        end
        sx = $urandom_range(0, 2 * 128 * METER) - 128 * METER;
        sy = $urandom_range(0, 2 * 128 * METER) - 128 * METER;
        dx = $urandom_range(0, 8 * METER) - 4 * METER;
        dy = $urandom_range(0, 8 * METER) - 4 * METER;
        if ($urandom_range(0, 9) == 0)
        begin
            dx = dx * 8;
            dy = dy * 8;
        end
        gx = sx + dx;
        gy = sy + dy;
        steps = $urandom_range(2, 14);
        for (k = 0; k <= steps + 2; k++)
        begin
            kk = k > steps ? steps : k;
            jit = $urandom_range(0, 1000) - 500;
            if ($urandom_range(0, 1))
                cv = $urandom_range(0, 3 * METER);
            else
                cv = $urandom;
            send_request(odometry(gx, gy, sx, sy,
                sx + int'((longint'(dx) * kk) / steps) + jit,
                sy + int'((longint'(dy) * kk) / steps) - jit, cv), 1'b0, none);
            if (!moving)
                break;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        dbvp_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (command_queue.size() == 0)
            begin
                $error("result with no request pending: %p", out_item);
                errors++;
            end
            else
            begin
                want = command_queue.pop_front();
                if (out_item.command_velocity !== want.command_velocity)
                begin
                    $error("command_velocity expected %0d actual %0d",
                        want.command_velocity, out_item.command_velocity);
                    errors++;
                end
                if (out_item.phase !== want.phase)
                begin
                    $error("phase expected %0d actual %0d", want.phase, out_item.phase);
                    errors++;
                end
                if (out_item.goal_done !== want.goal_done)
                begin
                    $error("goal_done expected %0d actual %0d", want.goal_done,
                        out_item.goal_done);
                    errors++;
                end
            end
        end
    end

    // receiver
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            n = calm ? 0 : $urandom_range(0, 12);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(rst_n && out_valid));
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        row_t rows[$];
        row_t row;
        dbvp_pkg::out_item_t none;
        none = '0;
        vmax = dbvp_pkg::RST_MAX_VELOCITY;
        ashare = dbvp_pkg::RST_ACCEL_SHARE;
        dshare = dbvp_pkg::RST_DECEL_SHARE;
        igain = dbvp_pkg::RST_INERTIA_GAIN;
        arate = dbvp_pkg::RST_ACCEL_RATE;
        vmin = dbvp_pkg::RST_MIN_DECEL_VEL;
        moving = 1'b0;
        prev_x = '0;
        prev_y = '0;
        trav = 0;
        path_total = 0;
        aspan = 0;
        rspan = 0;
        peak = 0;

        // zero length path ends at once
        rows.push_back('{odometry(0, 0, 0, 0, 0, 0, 0), 1'b1,
            '{0, dbvp_pkg::PH_DONE, 1'b1}});
        // corner to corner, distances saturate
        rows.push_back('{odometry(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 20'hFFFFF), 1'b1,
            '{0, dbvp_pkg::PH_ACCEL, 1'b0}});
        rows.push_back('{odometry(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 1'b1, '{0, dbvp_pkg::PH_DONE, 1'b1}});
        // short move, ramp capped, near goal zeroing
        rows.push_back('{odometry(METER, 0, 0, 0, METER * 3 / 10, 0, 0), 1'b0, none});
        rows.push_back('{odometry(METER, 0, 0, 0, METER * 35 / 100, 0, 20'hFFFFF), 1'b0, none});
        rows.push_back('{odometry(METER, 0, 0, 0, METER * 98 / 100, 0, 5000), 1'b0, none});
        rows.push_back('{odometry(METER, 0, 0, 0, METER, 0, 0), 1'b0, none});
        rows.push_back('{odometry(METER, 0, 0, 0, METER * 3 / 10, 0, 0), 1'b0, none});
        // long move through cruise and blended deceleration
        rows.push_back('{odometry(0, -10 * METER, 0, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{odometry(0, -10 * METER, 0, 0, 0, -METER, 3000), 1'b0, none});
        rows.push_back('{odometry(0, -10 * METER, 0, 0, 0, -3 * METER, METER), 1'b0, none});
        rows.push_back('{odometry(0, -10 * METER, 0, 0, 0, -6 * METER, 3 * METER), 1'b0, none});
        rows.push_back('{odometry(0, -10 * METER, 0, 0, 0, -9 * METER, 20'hFFFFF), 1'b0, none});
        rows.push_back('{odometry(0, -10 * METER, 0, 0, 0, -10 * METER, 0), 1'b0, none});
        rows.push_back('{odometry(-1, -1, 0, 0, -1, -1, 0), 1'b0, none});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        calm = 1'b1;
        foreach (rows[i])
        begin
            row = rows[i];
            send_request(row.item, row.typed, row.want);
            if (i == 4)
                calm = 1'b0;
        end

        sent = 0;
        while (sent < RANDOM_ITEMS / 5)
            random_move();
        load_profile($urandom_range(0, 20'hFFFFF), $urandom_range(1, 65536),
            $urandom_range(1, 65536), $urandom_range(0, 65536),
            $urandom_range(1, 20'hFFFFF), $urandom_range(0, 3 * METER));
        hold_request = 1'b1;
        while (sent < 2 * RANDOM_ITEMS / 5)
            random_move();
        load_profile(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        while (sent < 3 * RANDOM_ITEMS / 5)
            random_move();
        load_profile(0, 0, 0, 0, 0, 0);
        while (sent < 4 * RANDOM_ITEMS / 5)
            random_move();
        load_profile($urandom_range(METER / 4, 2 * METER), $urandom_range(1, 65536),
            $urandom_range(1, 65536), $urandom_range(0, 65536),
            $urandom_range(METER / 16, METER), $urandom_range(0, METER / 8));
        while (sent < RANDOM_ITEMS)
            random_move();

        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dbvp_pkg.sv
hw/rtl/dbvp_sqrt.sv
hw/rtl/dbvp_div.sv
hw/rtl/dbvp_dp.sv
hw/rtl/dbvp_ctrl.sv
hw/rtl/distance_based_velocity_profile.sv
dv/distance_based_velocity_profile_test.sv
